// ===== sv/adsr_envelope_generator_assert.svh =====
// assertion macros shared by the envelope generator rtl
`ifndef ADSR_ENVELOPE_GENERATOR_ASSERT_SVH
`define ADSR_ENVELOPE_GENERATOR_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define ADSR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ADSR_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== sv/adsr_pkg.sv =====
package adsr_pkg;

    // default width of the phase length registers
    localparam int LEN_WIDTH_DEF = 16;

    // quotient of one level computation, and its bit counter
    localparam int QUOT_WIDTH = 8;
    localparam int QBIT_WIDTH = $clog2(QUOT_WIDTH);

    // divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== sv/adsr_div.sv =====
module adsr_div
    import adsr_pkg::*;
#(
    parameter int LEN_WIDTH = LEN_WIDTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [LEN_WIDTH+QUOT_WIDTH-1:0]   num,
    input  logic [LEN_WIDTH-1:0]              den,
    output div_stat_t                         stat,
    output logic [QUOT_WIDTH-1:0]             quot
);

    localparam int NUM_WIDTH = LEN_WIDTH + QUOT_WIDTH;

    logic [NUM_WIDTH-1:0]  rem_reg, rem_next;
    logic [LEN_WIDTH-1:0]  den_reg, den_next;
    logic [QUOT_WIDTH-1:0] quot_reg, quot_next;
    logic [QBIT_WIDTH-1:0] bit_reg, bit_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [NUM_WIDTH-1:0]  den_shift;
    logic                  fits;

    // one compare and subtract per cycle, msb of the quotient first
    assign den_shift = NUM_WIDTH'(den_reg) << bit_reg;
    assign fits      = (rem_reg >= den_shift);

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            den_next  = den;
            quot_next = '0;
            bit_next  = QBIT_WIDTH'(QUOT_WIDTH - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next           = rem_reg - den_shift;
                quot_next[bit_reg] = 1'b1;
            end
            if (bit_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                bit_next = bit_reg - 1'b1;
            end
        end
    end

    // divider registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            bit_reg  <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;

endmodule

// ===== sv/adsr_envelope_generator.sv =====
// channel   | handshake           | payload
// ----------+---------------------+---------------------------------
// request   | req_valid/req_stall | restart
// result    | res_valid/res_stall | amplitude, segment, last
// config    | apb psel/penable    | paddr 4*i, pwdata (length regs)
//
// a request goes from acceptance through ST_SKIP, which steps past finished
// or empty phases, ST_DIV, which waits on the compare/subtract divider, and
// ST_OUT, which loads the output register; it goes straight to ST_OUT when every length is zero.
// req_stall is high from acceptance until the result is handed to the output
// register; a result may wait there while the next request is worked on.
// rst_n clears lengths, phase and index and leaves no result pending.
`include "adsr_envelope_generator_assert.svh"

module adsr_envelope_generator
    import adsr_pkg::*;
#(
    parameter int LEN_WIDTH = LEN_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        restart,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [7:0]  amplitude,
    output logic [1:0]  segment,
    output logic        last
);

    localparam int NUM_WIDTH = LEN_WIDTH + QUOT_WIDTH;

    localparam logic [1:0] REG_ATTACK  = 2'd0;
    localparam logic [1:0] REG_DECAY   = 2'd1;
    localparam logic [1:0] REG_SUSTAIN = 2'd2;
    localparam logic [1:0] REG_RELEASE = 2'd3;

    localparam logic [7:0] LEVEL_PEAK    = 8'd255;
    localparam logic [7:0] LEVEL_SUSTAIN = 8'd128;

    typedef enum logic [1:0] {
        SEG_ATTACK,
        SEG_DECAY,
        SEG_SUSTAIN,
        SEG_RELEASE
    } seg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SKIP,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t               state_reg, state_next;
    seg_t                 phase_reg, phase_next;
    logic [LEN_WIDTH-1:0] idx_reg, idx_next;
    logic [LEN_WIDTH-1:0] atk_len_reg, dec_len_reg, sus_len_reg, rel_len_reg;
    logic [7:0]           amp_pend_reg, amp_pend_next;
    seg_t                 seg_pend_reg, seg_pend_next;
    logic                 last_pend_reg, last_pend_next;
    logic                 res_valid_reg, res_valid_next;
    logic [7:0]           amplitude_reg, amplitude_next;
    logic [1:0]           segment_reg, segment_next;
    logic                 last_reg, last_next;

    logic                 cfg_write;
    logic                 req_accept;
    logic                 all_zero;
    logic [LEN_WIDTH-1:0] cur_len;
    logic                 later_nonzero;
    logic                 idx_fits;
    logic                 idx_at_end;
    logic                 div_start;
    logic [NUM_WIDTH-1:0] div_num;
    div_stat_t            div_stat;
    logic [7:0]           div_quot;
    logic [7:0]           level;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ATTACK:  prdata = 32'(atk_len_reg);
            REG_DECAY:   prdata = 32'(dec_len_reg);
            REG_SUSTAIN: prdata = 32'(sus_len_reg);
            REG_RELEASE: prdata = 32'(rel_len_reg);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atk_len_reg <= '0;
            dec_len_reg <= '0;
            sus_len_reg <= '0;
            rel_len_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_ATTACK:  atk_len_reg <= pwdata[LEN_WIDTH-1:0];
                REG_DECAY:   dec_len_reg <= pwdata[LEN_WIDTH-1:0];
                REG_SUSTAIN: sus_len_reg <= pwdata[LEN_WIDTH-1:0];
                REG_RELEASE: rel_len_reg <= pwdata[LEN_WIDTH-1:0];
                default:     ;
            endcase
        end
    end

    // length of the current phase and whether a later phase is nonempty
    always_comb
    begin
        unique case (phase_reg)
            SEG_ATTACK:
            begin
                cur_len       = atk_len_reg;
                later_nonzero = (dec_len_reg != '0) || (sus_len_reg != '0) ||
                                (rel_len_reg != '0);
            end
            SEG_DECAY:
            begin
                cur_len       = dec_len_reg;
                later_nonzero = (sus_len_reg != '0) || (rel_len_reg != '0);
            end
            SEG_SUSTAIN:
            begin
                cur_len       = sus_len_reg;
                later_nonzero = (rel_len_reg != '0);
            end
            SEG_RELEASE:
            begin
                cur_len       = rel_len_reg;
                later_nonzero = 1'b0;
            end
            default:
            begin
                cur_len       = '0;
                later_nonzero = 1'b0;
            end
        endcase
    end

    assign all_zero   = (atk_len_reg == '0) && (dec_len_reg == '0) &&
                        (sus_len_reg == '0) && (rel_len_reg == '0);
    assign idx_fits   = (idx_reg < cur_len);
    assign idx_at_end = ((LEN_WIDTH+1)'(idx_reg) + 1'b1) == (LEN_WIDTH+1)'(cur_len);

    // scaled index: idx*255 for attack, idx*128 for the falling ramps
    assign div_num = (phase_reg == SEG_ATTACK)
                   ? ({idx_reg, 8'h00} - NUM_WIDTH'(idx_reg))
                   : NUM_WIDTH'({idx_reg, 7'h00});
    assign div_start = (state_reg == ST_SKIP) && idx_fits;

    adsr_div #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (cur_len),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    // level of the sample from the quotient
    always_comb
    begin
        unique case (phase_reg)
            SEG_ATTACK:  level = div_quot;
            SEG_DECAY:   level = LEVEL_PEAK - div_quot;
            SEG_SUSTAIN: level = LEVEL_SUSTAIN;
            SEG_RELEASE: level = LEVEL_SUSTAIN - div_quot;
            default:     level = '0;
        endcase
    end

    assign req_accept = req_valid && !req_stall;

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        amp_pend_next  = amp_pend_reg;
        seg_pend_next  = seg_pend_reg;
        last_pend_next = last_pend_reg;
        res_valid_next = res_valid_reg && res_stall;
        amplitude_next = amplitude_reg;
        segment_next   = segment_reg;
        last_next      = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    if (restart || all_zero)
                    begin
                        phase_next = SEG_ATTACK;
                        idx_next   = '0;
                    end
                    if (all_zero)
                    begin
                        amp_pend_next  = '0;
                        seg_pend_next  = SEG_ATTACK;
                        last_pend_next = 1'b1;
                        state_next     = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_SKIP;
                    end
                end
            end
            ST_SKIP:
            begin
                // step past finished or empty phases, one per cycle
                if (idx_fits)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    phase_next = seg_t'(phase_reg + 2'd1);
                    idx_next   = '0;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    amp_pend_next  = level;
                    seg_pend_next  = phase_reg;
                    last_pend_next = idx_at_end && !later_nonzero;
                    if (idx_at_end)
                    begin
                        phase_next = seg_t'(phase_reg + 2'd1);
                        idx_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next = 1'b1;
                    amplitude_next = amp_pend_reg;
                    segment_next   = seg_pend_reg;
                    last_next      = last_pend_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= SEG_ATTACK;
            idx_reg       <= '0;
            amp_pend_reg  <= '0;
            seg_pend_reg  <= SEG_ATTACK;
            last_pend_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            amplitude_reg <= '0;
            segment_reg   <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            amp_pend_reg  <= amp_pend_next;
            seg_pend_reg  <= seg_pend_next;
            last_pend_reg <= last_pend_next;
            res_valid_reg <= res_valid_next;
            amplitude_reg <= amplitude_next;
            segment_reg   <= segment_next;
            last_reg      <= last_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign amplitude = amplitude_reg;
    assign segment   = segment_reg;
    assign last      = last_reg;

    // checks on the sequencer and the level computation
    `ADSR_ASSERT(a_idle_div_quiet, (state_reg == ST_IDLE) |-> !div_stat.busy,
        "divider busy while sequencer idle")
    `ADSR_ASSERT(a_div_in_range, div_start |-> (cur_len != '0),
        "division started on an empty phase")
    `ADSR_NEVER(a_release_level, res_valid_reg && (segment_reg == SEG_RELEASE) &&
        (amplitude_reg > LEVEL_SUSTAIN), "release level above sustain")
    `ADSR_NEVER(a_decay_level, res_valid_reg && (segment_reg == SEG_DECAY) &&
        (amplitude_reg < LEVEL_SUSTAIN), "decay level below sustain")

endmodule
